FILE: design/assert_macros.svh
// Assertion macros shared by the receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rclbh_pkg.sv
// Types, constants and helpers shared by the receiver modules.
`timescale 1ns / 1ps

package rclbh_pkg;

  // Packet store and hop table sizes.
  localparam int PACKET_BYTES = 16;
  localparam int HOP_CHANNELS = 4;
  localparam int STORE_IDX_W  = $clog2(PACKET_BYTES);
  localparam int HOP_IDX_W    = $clog2(HOP_CHANNELS);

  // Byte position saturates at 31 whatever the store size.
  localparam int              POS_W   = 5;
  localparam logic [POS_W-1:0] POS_MAX = 5'd31;

  // Miss counter is 18-bit signed and saturates at its largest positive value.
  localparam int                      MISS_W   = 18;
  localparam logic signed [MISS_W-1:0] MISS_MAX = 18'sd131071;

  // Bind signature "KNDZ" in bytes 0 to 3.
  localparam logic [7:0] SIG_0 = 8'h4b;
  localparam logic [7:0] SIG_1 = 8'h4e;
  localparam logic [7:0] SIG_2 = 8'h44;
  localparam logic [7:0] SIG_3 = 8'h5a;

  // Byte positions inside a packet.
  localparam int ADDR_POS    = 4;
  localparam int HOP_POS     = 8;
  localparam int RATE_POS    = 15;
  localparam int TRIM_POS    = 8;
  localparam int SWITCH_POS  = 12;
  localparam int HOP_CMD_POS = 13;

  localparam logic [1:0] HOP_CMD   = 2'b11;
  localparam logic [7:0] RATE_MASK = 8'b00000001;

  // Configuration port.
  localparam int               CFG_IDX_W        = 2;
  localparam int               CFG_DATA_W       = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BIND_CHANNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIND_GRACE   = 2'd2;

  localparam logic [6:0]  BIND_CHANNEL_RESET = 7'd0;
  localparam logic [15:0] MISS_LIMIT_RESET   = 16'd1000;
  localparam logic [15:0] BIND_GRACE_RESET   = 16'd5000;

  typedef enum logic [2:0] {
    EV_TICK        = 3'd0,
    EV_BIND_OK     = 3'd1,
    EV_BIND_REJECT = 3'd2,
    EV_CONTROL     = 3'd3,
    EV_SHORT       = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    event_kind_t        event_kind;
    logic               is_bound;
    logic [7:0]         rf_channel;
    logic               rate_fast;
    logic               link_ok;
    logic signed [15:0] stick_left_y;
    logic signed [15:0] stick_right_x;
    logic signed [15:0] stick_right_y;
    logic signed [15:0] stick_left_x;
    logic [31:0]        trim_word;
    logic [3:0]         switch_bits;
    logic [31:0]        link_address;
  } out_item_t;

  typedef logic [PACKET_BYTES-1:0][7:0] packet_t;
  typedef logic [HOP_CHANNELS-1:0][7:0] hop_table_t;

  // One request as it is processed: fire marks the cycle it takes effect.
  typedef struct packed {
    logic       fire;
    logic       is_byte;
    logic       is_last;
    logic [7:0] data;
  } step_t;

  // Byte of a packet at a constant position; positions past the store read zero.
  function automatic logic [7:0] pkt_byte(packet_t p, int pos);
    logic [7:0] b;
    b = '0;
    if (pos < PACKET_BYTES) begin
      b = p[STORE_IDX_W'(pos)];
    end
    return b;
  endfunction

endpackage

FILE: design/rc_link_bind_hop_receiver_core.sv
// Top level of the bind and hop receiver: request register, processing and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The receiver takes one request per clock cycle: a poll tick or one payload
// byte. Each request is held in an input register and processed once its
// result can be stored, by single-pass logic that updates the packet store
// and link state and loads the result register, so a result passes through
// the input register and then the result register. Ticks and last bytes give
// one result each; other bytes give none. in_ready stays high while the
// result register can drain into the output in the same cycle, so
// back-to-back requests flow at one per cycle unless out_ready is held low
// with a result waiting. Configuration writes are registered and are meant
// for idle periods.
module rc_link_bind_hop_receiver_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rclbh_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rclbh_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [rclbh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rclbh_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                 req_valid;
  rclbh_pkg::in_item_t  req;
  logic                 produces;
  logic                 proc_fire;
  rclbh_pkg::step_t     step;
  rclbh_pkg::packet_t   pkt_view;
  logic                 multi_byte;
  rclbh_pkg::out_item_t result;

  // A held request fires unless its result would overwrite one still waiting.
  assign produces  = !req.mode || req.last_byte;
  assign proc_fire = req_valid && (!produces || !out_valid || out_ready);
  assign in_ready  = !req_valid || proc_fire;

  assign step.fire    = proc_fire;
  assign step.is_byte = req.mode;
  assign step.is_last = req.last_byte;
  assign step.data    = req.data_byte;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
  end

  rclbh_pkt_store u_store (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pkt_view  (pkt_view),
    .multi_byte(multi_byte)
  );

  rclbh_link_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .pkt_view  (pkt_view),
    .multi_byte(multi_byte),
    .result    (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && produces) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && produces) begin
      out_data <= result;
    end
  end

  `ASSERT_IMPLIES(a_bind_reports_bound, clk, rst,
    out_valid && out_data.event_kind == rclbh_pkg::EV_BIND_OK, out_data.is_bound,
    "bind accepted without the bound flag")

endmodule

FILE: design/rclbh_pkt_store.sv
// Packet byte store and write position, with a view that includes the current byte.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rclbh_pkt_store (
  input  logic            clk,
  input  logic            rst,
  input  rclbh_pkg::step_t   step,
  output rclbh_pkg::packet_t pkt_view,
  output logic            multi_byte
);

  logic [rclbh_pkg::POS_W-1:0] position;
  logic [rclbh_pkg::POS_W-1:0] position_next;
  rclbh_pkg::packet_t          store;

  // Merge the incoming byte into the stored packet at the write position.
  always_comb begin
    pkt_view = store;
    for (int j = 0; j < rclbh_pkg::PACKET_BYTES; j++) begin
      if (step.is_byte && position == rclbh_pkg::POS_W'(j)) begin
        pkt_view[j] = step.data;
      end
    end
  end

  // A byte at position one or later closes a packet of two or more bytes.
  assign multi_byte = (position != '0);

  // Advance with saturation; a last byte rewinds to the start.
  always_comb begin
    position_next = position;
    if (step.is_byte) begin
      if (step.is_last) begin
        position_next = '0;
      end else if (position != rclbh_pkg::POS_MAX) begin
        position_next = position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      store    <= '0;
    end else if (step.fire) begin
      position <= position_next;
      store    <= pkt_view;
    end
  end

  `ASSERT_NEXT(a_last_rewinds, clk, rst, step.fire && step.is_byte && step.is_last,
    position == '0, "byte position not rewound after a last byte")

endmodule

FILE: design/rclbh_link_ctrl.sv
// Link state: binding, hopping, miss counting, configuration and result decode.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rclbh_link_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rclbh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rclbh_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  rclbh_pkg::step_t                     step,
  input  rclbh_pkg::packet_t                   pkt_view,
  input  logic                                 multi_byte,
  output rclbh_pkg::out_item_t                 result
);

  // Configuration registers.
  logic [6:0]  bind_channel;
  logic [15:0] miss_limit;
  logic [15:0] bind_grace;

  // Link state.
  logic                                bound;
  logic                                bound_next;
  logic [rclbh_pkg::HOP_IDX_W-1:0]     hop_idx;
  logic [rclbh_pkg::HOP_IDX_W-1:0]     hop_idx_next;
  rclbh_pkg::hop_table_t               hop_table;
  rclbh_pkg::hop_table_t               hop_table_next;
  logic [31:0]                         address;
  logic [31:0]                         address_next;
  logic                                fast;
  logic                                fast_next;
  logic signed [rclbh_pkg::MISS_W-1:0] miss;
  logic signed [rclbh_pkg::MISS_W-1:0] miss_next;
  logic signed [rclbh_pkg::MISS_W-1:0] miss_inc;

  logic              sig_ok;
  logic              hop_req;
  logic [7:0]        cmd_byte;
  logic [7:0]        sw_byte;
  rclbh_pkg::event_kind_t ev;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bind_channel <= rclbh_pkg::BIND_CHANNEL_RESET;
      miss_limit   <= rclbh_pkg::MISS_LIMIT_RESET;
      bind_grace   <= rclbh_pkg::BIND_GRACE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rclbh_pkg::REG_BIND_CHANNEL: bind_channel <= cfg_data[6:0];
        rclbh_pkg::REG_MISS_LIMIT:   miss_limit   <= cfg_data;
        rclbh_pkg::REG_BIND_GRACE:   bind_grace   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Signature, hop command and switch byte of the current packet.
  assign sig_ok = rclbh_pkg::pkt_byte(pkt_view, 0) == rclbh_pkg::SIG_0 &&
                  rclbh_pkg::pkt_byte(pkt_view, 1) == rclbh_pkg::SIG_1 &&
                  rclbh_pkg::pkt_byte(pkt_view, 2) == rclbh_pkg::SIG_2 &&
                  rclbh_pkg::pkt_byte(pkt_view, 3) == rclbh_pkg::SIG_3;
  assign cmd_byte = rclbh_pkg::pkt_byte(pkt_view, rclbh_pkg::HOP_CMD_POS);
  assign hop_req  = cmd_byte[6:5] == rclbh_pkg::HOP_CMD;
  assign sw_byte  = rclbh_pkg::pkt_byte(pkt_view, rclbh_pkg::SWITCH_POS);

  // Saturating miss increment.
  assign miss_inc = (miss == rclbh_pkg::MISS_MAX) ? miss : miss + 1'b1;

  // Next link state and event kind.
  always_comb begin
    bound_next     = bound;
    hop_idx_next   = hop_idx;
    hop_table_next = hop_table;
    address_next   = address;
    fast_next      = fast;
    miss_next      = miss;
    ev             = rclbh_pkg::EV_TICK;
    if (!step.is_byte) begin
      if (bound) begin
        miss_next = miss_inc;
      end
    end else if (step.is_last) begin
      if (!bound) begin
        if (sig_ok) begin
          for (int i = 0; i < 4; i++) begin
            address_next[8*i +: 8] = rclbh_pkg::pkt_byte(pkt_view, rclbh_pkg::ADDR_POS + i);
          end
          for (int i = 0; i < rclbh_pkg::HOP_CHANNELS; i++) begin
            hop_table_next[i] = rclbh_pkg::pkt_byte(pkt_view, rclbh_pkg::HOP_POS + i);
          end
          fast_next  = (rclbh_pkg::pkt_byte(pkt_view, rclbh_pkg::RATE_POS) &
                        rclbh_pkg::RATE_MASK) != '0;
          bound_next = 1'b1;
          miss_next  = -$signed({2'b00, bind_grace});
          ev         = rclbh_pkg::EV_BIND_OK;
        end else begin
          ev = rclbh_pkg::EV_BIND_REJECT;
        end
      end else if (multi_byte) begin
        if (hop_req) begin
          if (hop_idx == rclbh_pkg::HOP_IDX_W'(rclbh_pkg::HOP_CHANNELS - 1)) begin
            hop_idx_next = '0;
          end else begin
            hop_idx_next = hop_idx + 1'b1;
          end
        end
        miss_next = '0;
        ev        = rclbh_pkg::EV_CONTROL;
      end else begin
        miss_next = miss_inc;
        ev        = rclbh_pkg::EV_SHORT;
      end
    end
  end

  // Result fields, taken from the state as it stands after this request.
  always_comb begin
    result            = '0;
    result.event_kind = ev;
    result.is_bound   = bound_next;
    result.rf_channel = bound_next ? hop_table_next[hop_idx_next] : {1'b0, bind_channel};
    result.rate_fast  = fast_next;
    result.link_ok    = miss_next < $signed({2'b00, miss_limit});
    result.link_address = bound_next ? address_next : '0;
    if (ev == rclbh_pkg::EV_CONTROL) begin
      result.stick_left_y  = $signed({pkt_view[0], pkt_view[1]});
      result.stick_right_x = $signed({pkt_view[2], pkt_view[3]});
      result.stick_right_y = $signed({pkt_view[4], pkt_view[5]});
      result.stick_left_x  = $signed({pkt_view[6], pkt_view[7]});
      for (int i = 0; i < 4; i++) begin
        result.trim_word[8*i +: 8] = rclbh_pkg::pkt_byte(pkt_view, rclbh_pkg::TRIM_POS + i);
      end
      result.switch_bits = {sw_byte[7:6] != 2'b00, sw_byte[2:0]};
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bound   <= 1'b0;
      hop_idx <= '0;
      fast    <= 1'b1;
      miss    <= '0;
    end else if (step.fire) begin
      bound   <= bound_next;
      hop_idx <= hop_idx_next;
      fast    <= fast_next;
      miss    <= miss_next;
    end
  end

  // Learned hop table and address are only read once bound.
  always_ff @(posedge clk) begin
    if (step.fire) begin
      hop_table <= hop_table_next;
      address   <= address_next;
    end
  end

  `ASSERT_NEXT(a_bound_sticks, clk, rst, bound, bound, "link left the bound state")
  `ASSERT_IMPLIES(a_unbound_no_miss, clk, rst, !bound, miss == '0,
    "miss counter moved while unbound")

endmodule
